@@ design/nmea_chk_pkg.sv @@
// ----------------------------------------------------------------------------
// nmea_chk_pkg
// Shared constants, types and helper functions for the NMEA sentence checker.
// ----------------------------------------------------------------------------
package nmea_chk_pkg;

    localparam int ByteW   = 8;
    localparam int PhaseW  = 2;
    localparam int KindW   = 2;
    localparam int PosW    = 3;
    localparam int NumIds  = 3;
    localparam int IdLen   = 5;
    localparam int TdataW  = 24;

    localparam logic [PhaseW-1:0] PH_IDLE = 2'd0;
    localparam logic [PhaseW-1:0] PH_BODY = 2'd1;
    localparam logic [PhaseW-1:0] PH_HIGH = 2'd2;
    localparam logic [PhaseW-1:0] PH_LOW  = 2'd3;

    localparam logic [KindW-1:0] KIND_OTHER = 2'd0;
    localparam logic [KindW-1:0] KIND_GNGGA = 2'd1;
    localparam logic [KindW-1:0] KIND_GNGSA = 2'd2;
    localparam logic [KindW-1:0] KIND_GNRMC = 2'd3;

    localparam logic [ByteW-1:0] CH_DOLLAR = 8'h24;
    localparam logic [ByteW-1:0] CH_STAR   = 8'h2A;
    localparam logic [ByteW-1:0] CH_COMMA  = 8'h2C;
    localparam logic [ByteW-1:0] CH_ZERO   = 8'h30;
    localparam logic [ByteW-1:0] CH_NINE   = 8'h39;
    localparam logic [ByteW-1:0] CH_UPPER_A = 8'h41;
    localparam logic [ByteW-1:0] CH_UPPER_F = 8'h46;

    localparam logic [IdLen*ByteW-1:0] ID_GNGGA = "GNGGA";
    localparam logic [IdLen*ByteW-1:0] ID_GNGSA = "GNGSA";
    localparam logic [IdLen*ByteW-1:0] ID_GNRMC = "GNRMC";

    typedef struct packed {
        logic              checksum_ok;
        logic [KindW-1:0]  sentence_kind;
        logic [ByteW-1:0]  computed_checksum;
        logic [ByteW-1:0]  received_checksum;
        logic              digits_valid;
    } result_t;

    typedef struct packed {
        logic       bad;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [ByteW-1:0] c);
        hex_t h;
        h.bad   = 1'b0;
        h.value = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            h.value = 4'(c - CH_ZERO);
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            h.value = 4'(c - CH_UPPER_A + 8'd10);
        end else begin
            h.bad = 1'b1;
        end
        return h;
    endfunction

    // character at position pos of a five-character name, first character first
    function automatic logic [ByteW-1:0] id_char(input logic [IdLen*ByteW-1:0] name,
                                                 input logic [PosW-1:0] pos);
        logic [ByteW-1:0] ch;
        ch = 8'd0;
        unique case (pos)
            3'd0:    ch = name[39:32];
            3'd1:    ch = name[31:24];
            3'd2:    ch = name[23:16];
            3'd3:    ch = name[15:8];
            3'd4:    ch = name[7:0];
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

endpackage

@@ design/nmea_sentence_checker_top.sv @@
// ----------------------------------------------------------------------------
// nmea_sentence_checker_top
// Checks NMEA 0183 sentence checksums and names the sentence type.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one received character per transaction in s_tdata.
//   A '$' opens a sentence (also in mid-sentence, restarting it); the XOR of
//   the characters up to '*' is compared to the two hex digits after it.
//   The m_ channel gives one result transaction per sentence, on the second
//   checksum digit; other characters give no result.
//   The result is registered when the second digit is accepted, in the skid
//   register if the output one waits. Throughput: one character every cycle
//   while s_tready is high, set by the single registered frame state update.
//   The result sits in an output register backed by one skid register, so
//   a character is still taken while a result waits; s_tready is low while
//   the skid register holds a result, which needs a second result to arrive
//   while the output register waits on m_tready.
//   Reset (aresetn low, synchronous) returns the block to idle, waiting for
//   '$', and empties the output and skid registers.
// ----------------------------------------------------------------------------
module nmea_sentence_checker_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // checksum_ok, computed_checksum, received_checksum,
                                   // digits_valid, zero fill
    output logic [1:0]  m_tuser    // sentence_kind
);

    localparam int ByteW  = nmea_chk_pkg::ByteW;
    localparam int PhaseW = nmea_chk_pkg::PhaseW;
    localparam int PosW   = nmea_chk_pkg::PosW;
    localparam int NumIds = nmea_chk_pkg::NumIds;

    logic [PhaseW-1:0] phase_reg, phase_next;
    logic [ByteW-1:0]  xor_reg, xor_next;
    logic [3:0]        high_reg, high_next;
    logic              high_bad_reg, high_bad_next;
    logic [PosW-1:0]   pos_reg, pos_next;
    logic [NumIds-1:0] match_reg, match_next;
    logic              closed_reg, closed_next;

    nmea_chk_pkg::result_t res_comb, out_reg, skid_reg;
    logic out_valid_reg, skid_valid_reg;
    logic res_fire;

    logic [ByteW-1:0]   c;
    logic               accept;
    nmea_chk_pkg::hex_t hex;
    logic [ByteW-1:0]   recv;
    logic               valid;

    assign c      = s_tdata;
    assign accept = s_tvalid && s_tready;
    assign hex    = nmea_chk_pkg::hex_decode(c);
    assign recv   = {high_reg, hex.value};
    assign valid  = !(high_bad_reg || hex.bad);

    always_comb begin
        phase_next    = phase_reg;
        xor_next      = xor_reg;
        high_next     = high_reg;
        high_bad_next = high_bad_reg;
        pos_next      = pos_reg;
        match_next    = match_reg;
        closed_next   = closed_reg;
        res_fire      = 1'b0;

        res_comb.checksum_ok       = valid && (recv == xor_reg);
        res_comb.computed_checksum = xor_reg;
        res_comb.received_checksum = recv;
        res_comb.digits_valid      = valid;
        res_comb.sentence_kind     = nmea_chk_pkg::KIND_OTHER;
        if (closed_reg) begin
            priority if (match_reg[0]) begin
                res_comb.sentence_kind = nmea_chk_pkg::KIND_GNGGA;
            end else if (match_reg[1]) begin
                res_comb.sentence_kind = nmea_chk_pkg::KIND_GNGSA;
            end else if (match_reg[2]) begin
                res_comb.sentence_kind = nmea_chk_pkg::KIND_GNRMC;
            end else begin
                res_comb.sentence_kind = nmea_chk_pkg::KIND_OTHER;
            end
        end

        if (accept) begin
            if (c == nmea_chk_pkg::CH_DOLLAR) begin
                phase_next    = nmea_chk_pkg::PH_BODY;
                xor_next      = '0;
                high_next     = '0;
                high_bad_next = 1'b0;
                pos_next      = '0;
                match_next    = '1;
                closed_next   = 1'b0;
            end else begin
                unique case (phase_reg)
                    nmea_chk_pkg::PH_IDLE: begin
                    end
                    nmea_chk_pkg::PH_BODY: begin
                        if (c == nmea_chk_pkg::CH_STAR) begin
                            phase_next = nmea_chk_pkg::PH_HIGH;
                        end else begin
                            xor_next = xor_reg ^ c;
                            if (!closed_reg) begin
                                if (c == nmea_chk_pkg::CH_COMMA) begin
                                    closed_next = 1'b1;
                                    if (pos_reg != PosW'(nmea_chk_pkg::IdLen)) begin
                                        match_next = '0;
                                    end
                                end else if (pos_reg < PosW'(nmea_chk_pkg::IdLen)) begin
                                    if (nmea_chk_pkg::id_char(nmea_chk_pkg::ID_GNGGA,
                                                              pos_reg) != c) begin
                                        match_next[0] = 1'b0;
                                    end
                                    if (nmea_chk_pkg::id_char(nmea_chk_pkg::ID_GNGSA,
                                                              pos_reg) != c) begin
                                        match_next[1] = 1'b0;
                                    end
                                    if (nmea_chk_pkg::id_char(nmea_chk_pkg::ID_GNRMC,
                                                              pos_reg) != c) begin
                                        match_next[2] = 1'b0;
                                    end
                                    pos_next = pos_reg + 1'b1;
                                end else begin
                                    match_next = '0;
                                end
                            end
                        end
                    end
                    nmea_chk_pkg::PH_HIGH: begin
                        high_next     = hex.value;
                        high_bad_next = hex.bad;
                        phase_next    = nmea_chk_pkg::PH_LOW;
                    end
                    nmea_chk_pkg::PH_LOW: begin
                        res_fire   = 1'b1;
                        phase_next = nmea_chk_pkg::PH_IDLE;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= nmea_chk_pkg::PH_IDLE;
            xor_reg      <= '0;
            high_reg     <= '0;
            high_bad_reg <= 1'b0;
            pos_reg      <= '0;
            match_reg    <= '1;
            closed_reg   <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            xor_reg      <= xor_next;
            high_reg     <= high_next;
            high_bad_reg <= high_bad_next;
            pos_reg      <= pos_next;
            match_reg    <= match_next;
            closed_reg   <= closed_next;
        end
    end

    // output register with one skid entry
    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= res_fire;
                end else begin
                    out_valid_reg <= res_fire;
                end
            end else if (res_fire) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
                if (res_fire) begin
                    skid_reg <= res_comb;
                end
            end else if (res_fire) begin
                out_reg <= res_comb;
            end
        end else if (res_fire) begin
            skid_reg <= res_comb;
        end
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.sentence_kind;
    assign m_tdata  = {6'd0,
                       out_reg.digits_valid,
                       out_reg.received_checksum,
                       out_reg.computed_checksum,
                       out_reg.checksum_ok};

endmodule

@@ tb/nmea_sentence_checker_top_tb.sv @@
// ----------------------------------------------------------------------------
// nmea_sentence_checker_top_tb
// Drives character streams into the sentence checker and compares every
// result transaction against a cycle-free model of the frame and field logic.
// Stimulus is a short directed run, then random sentences with well-formed
// framing and random content, mixed with noise, broken checksums and
// restarts. Both sides idle at random; the receiver also stalls for a long
// stretch so that the output and skid registers fill and s_tready drops.
// ----------------------------------------------------------------------------
module nmea_sentence_checker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 200000;
    localparam int CharTarget = 1525;
    localparam int HoldCycles = 400;

    class sentence_tracker;
        logic [nmea_chk_pkg::PhaseW-1:0]                   phase;
        logic [nmea_chk_pkg::ByteW-1:0]                    xsum;
        logic [3:0]                                        hi;
        logic                                              hi_bad;
        logic [nmea_chk_pkg::PosW-1:0]                     pos;
        logic [nmea_chk_pkg::NumIds-1:0]                   flags;
        logic                                              closed;
        logic [nmea_chk_pkg::IdLen*nmea_chk_pkg::ByteW-1:0] id_table [nmea_chk_pkg::NumIds];
        nmea_chk_pkg::result_t                             pending [$];
        int                                                mismatches;

        function new();
            id_table   = '{nmea_chk_pkg::ID_GNGGA, nmea_chk_pkg::ID_GNGSA,
                           nmea_chk_pkg::ID_GNRMC};
            phase      = nmea_chk_pkg::PH_IDLE;
            xsum       = '0;
            hi         = '0;
            hi_bad     = 1'b0;
            pos        = '0;
            flags      = '1;
            closed     = 1'b0;
            mismatches = 0;
        endfunction

        function void digit_of(input logic [nmea_chk_pkg::ByteW-1:0] c,
                               output logic [3:0] v, output logic bad);
            bad = 1'b0;
            v   = 4'd0;
            if (c >= nmea_chk_pkg::CH_ZERO && c <= nmea_chk_pkg::CH_NINE)
                v = c[3:0];
            else if (c >= nmea_chk_pkg::CH_UPPER_A && c <= nmea_chk_pkg::CH_UPPER_F)
                v = 4'(c - nmea_chk_pkg::CH_UPPER_A + 8'd10);
            else
                bad = 1'b1;
        endfunction

        function void take_char(input logic [nmea_chk_pkg::ByteW-1:0] c);
            logic [3:0]            lo;
            logic                  lo_bad;
            nmea_chk_pkg::result_t r;
            if (c == nmea_chk_pkg::CH_DOLLAR) begin
                phase  = nmea_chk_pkg::PH_BODY;
                xsum   = '0;
                hi     = '0;
                hi_bad = 1'b0;
                pos    = '0;
                flags  = '1;
                closed = 1'b0;
                return;
            end
            case (phase)
                nmea_chk_pkg::PH_BODY: begin
                    if (c == nmea_chk_pkg::CH_STAR) begin
                        phase = nmea_chk_pkg::PH_HIGH;
                    end else begin
                        xsum ^= c;
                        if (!closed) begin
                            if (c == nmea_chk_pkg::CH_COMMA) begin
                                closed = 1'b1;
                                if (pos != nmea_chk_pkg::IdLen)
                                    flags = '0;
                            end else if (pos < nmea_chk_pkg::IdLen) begin
                                for (int k = 0; k < nmea_chk_pkg::NumIds; k++)
                                    if (id_table[k][nmea_chk_pkg::ByteW *
                                                    (nmea_chk_pkg::IdLen - 1 - pos)
                                                    +: nmea_chk_pkg::ByteW] != c)
                                        flags[k] = 1'b0;
                                pos++;
                            end else begin
                                flags = '0;
                            end
                        end
                    end
                end
                nmea_chk_pkg::PH_HIGH: begin
                    digit_of(c, hi, hi_bad);
                    phase = nmea_chk_pkg::PH_LOW;
                end
                nmea_chk_pkg::PH_LOW: begin
                    digit_of(c, lo, lo_bad);
                    r.received_checksum = {hi, lo};
                    r.computed_checksum = xsum;
                    r.digits_valid      = !(hi_bad || lo_bad);
                    r.checksum_ok       = r.digits_valid && ({hi, lo} == xsum);
                    if (!closed)       r.sentence_kind = nmea_chk_pkg::KIND_OTHER;
                    else if (flags[0]) r.sentence_kind = nmea_chk_pkg::KIND_GNGGA;
                    else if (flags[1]) r.sentence_kind = nmea_chk_pkg::KIND_GNGSA;
                    else if (flags[2]) r.sentence_kind = nmea_chk_pkg::KIND_GNRMC;
                    else               r.sentence_kind = nmea_chk_pkg::KIND_OTHER;
                    pending.push_back(r);
                    phase = nmea_chk_pkg::PH_IDLE;
                end
                default: ;
            endcase
        endfunction

        function void compare_report(input logic [23:0] tdata, input logic [1:0] tuser);
            nmea_chk_pkg::result_t want;
            if (pending.size() == 0) begin
                $error("result transaction with no sentence pending: %h/%h", tdata, tuser);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (tdata[0] !== want.checksum_ok) begin
                $error("checksum_ok: expected %b, actual %b", want.checksum_ok, tdata[0]);
                mismatches++;
            end
            if (tdata[8:1] !== want.computed_checksum) begin
                $error("computed_checksum: expected %h, actual %h",
                       want.computed_checksum, tdata[8:1]);
                mismatches++;
            end
            if (tdata[16:9] !== want.received_checksum) begin
                $error("received_checksum: expected %h, actual %h",
                       want.received_checksum, tdata[16:9]);
                mismatches++;
            end
            if (tdata[17] !== want.digits_valid) begin
                $error("digits_valid: expected %b, actual %b", want.digits_valid, tdata[17]);
                mismatches++;
            end
            if (tdata[23:18] !== 6'd0) begin
                $error("zero fill: expected %h, actual %h", 6'd0, tdata[23:18]);
                mismatches++;
            end
            if (tuser !== want.sentence_kind) begin
                $error("sentence_kind: expected %d, actual %d", want.sentence_kind, tuser);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    sentence_tracker tracker = new();
    int chars_sent  = 0;
    int cycle_count = 0;
    bit steady      = 1'b0;
    bit hold_req    = 1'b0;

    nmea_sentence_checker_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result transactions
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.compare_report(m_tdata, m_tuser);
    end

    // receiver side
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
                hold_req = 1'b0;
            end else if (steady || !aresetn) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 9);
            end
        end
    end

    task automatic send_char(input logic [7:0] c);
        if (!steady && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        tracker.take_char(c);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 10) ? nmea_chk_pkg::CH_ZERO + n
                        : nmea_chk_pkg::CH_UPPER_A + n - 8'd10;
    endfunction

    task automatic send_hex_pair(input logic [7:0] v);
        send_char(hex_char(v[7:4]));
        send_char(hex_char(v[3:0]));
    endtask

    // any byte that is neither a hex digit nor a dollar
    function automatic logic [7:0] nonhex_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if ((c >= nmea_chk_pkg::CH_ZERO && c <= nmea_chk_pkg::CH_NINE)
            || (c >= nmea_chk_pkg::CH_UPPER_A && c <= nmea_chk_pkg::CH_UPPER_F)
            || c == nmea_chk_pkg::CH_DOLLAR)
            c = "a" + 8'($urandom_range(0, 5));
        return c;
    endfunction

    task automatic send_sentence();
        logic [7:0] c;
        logic [7:0] sum;
        string      name;
        int         n;
        if ($urandom_range(0, 99) < 15) begin
            n = $urandom_range(1, 12);
            repeat (n) begin
                c = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) == 0)
                    c = $urandom_range(0, 1) ? nmea_chk_pkg::CH_DOLLAR
                                             : nmea_chk_pkg::CH_STAR;
                send_char(c);
            end
            return;
        end
        send_char(nmea_chk_pkg::CH_DOLLAR);
        sum = 8'd0;
        case ($urandom_range(0, 9))
            0, 1:    name = "GNGGA";
            2, 3:    name = "GNGSA";
            4, 5:    name = "GNRMC";
            6:       name = "GNGG";
            7:       name = "GNRMCC";
            8:       name = "GPGGA";
            default: name = "";
        endcase
        if (name.len() > 0 && $urandom_range(0, 4) == 0)
            name[$urandom_range(0, name.len() - 1)] = "A" + 8'($urandom_range(0, 57));
        for (int i = 0; i < name.len(); i++) begin
            send_char(name[i]);
            sum ^= name[i];
        end
        if ($urandom_range(0, 9) != 0) begin
            send_char(nmea_chk_pkg::CH_COMMA);
            sum ^= nmea_chk_pkg::CH_COMMA;
        end
        n = $urandom_range(0, 10);
        repeat (n) begin
            c = 8'($urandom_range(0, 255));
            if (c == nmea_chk_pkg::CH_DOLLAR || c == nmea_chk_pkg::CH_STAR)
                c ^= 8'h40;
            if ($urandom_range(0, 39) == 0) begin
                c   = nmea_chk_pkg::CH_DOLLAR;
                sum = 8'd0;
            end else begin
                sum ^= c;
            end
            send_char(c);
        end
        send_char(nmea_chk_pkg::CH_STAR);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: send_hex_pair(sum);
            6:                send_hex_pair(8'($urandom_range(0, 255)));
            7: begin
                send_char(nonhex_char());
                send_char(hex_char(sum[3:0]));
            end
            8: begin
                send_char(hex_char(sum[7:4]));
                send_char(nonhex_char());
            end
            default: begin
                if ($urandom_range(0, 1))
                    send_char(hex_char(sum[7:4]));
                send_char(nmea_chk_pkg::CH_DOLLAR);
            end
        endcase
    endtask

    initial begin
        logic [7:0] sum;
        int         sentences;
        string      field;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // ignored while idle
        send_char(8'h00);
        send_char(8'hFF);
        field = "GNGSA,";
        sum   = 8'd0;
        for (int i = 0; i < field.len(); i++)
            sum ^= field[i];
        send_text({"$", field, "*"});
        send_hex_pair(sum);
        // restart while the low digit is due
        send_char(nmea_chk_pkg::CH_DOLLAR);
        send_char(8'hFF);
        send_text("*0$");
        // empty body, lowercase high digit
        send_text("*g0");
        send_char(nmea_chk_pkg::CH_DOLLAR);
        send_char(8'h00);
        send_text("*00");

        sentences = 0;
        while (chars_sent < CharTarget) begin
            if (sentences == 60)
                hold_req = 1'b1;
            steady = (sentences >= 75 && sentences < 105);
            send_sentence();
            sentences++;
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (tracker.pending.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
